// ===== sv/dsd_pkg.sv =====
// Package for the depth sort by distance unit.
// Holds widths, capacity constants and register index codes; no dependencies.
package dsd_pkg;

	localparam int MAX_OBJECTS = 64;
	localparam int COORD_W     = 24;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int DIST_W      = 50;
	localparam int INDEX_W     = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int ADDR_W      = $clog2(MAX_OBJECTS);
	localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [DIST_W-1:0]         dist_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [CNT_W-1:0]          cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIEWER_X = 2'd0,
		CFG_VIEWER_Y = 2'd1,
		CFG_VIEWER_Z = 2'd2
	} cfg_idx_t;

endpackage

// ===== sv/dsd_dist.sv =====
// Squared distance pipeline: difference, square, sum in three register stages.
// Depends on dsd_pkg.
module dsd_dist (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  dsd_pkg::coord_t viewer_x,
	input  dsd_pkg::coord_t viewer_y,
	input  dsd_pkg::coord_t viewer_z,
	input  dsd_pkg::coord_t obj_x,
	input  dsd_pkg::coord_t obj_y,
	input  dsd_pkg::coord_t obj_z,
	output logic           out_valid,
	output dsd_pkg::dist_t dist_sq
);
	import dsd_pkg::*;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	dist_t sqx_s2, sqy_s2, sqz_s2;
	dist_t sum_s3;
	logic  vld_s1, vld_s2, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= DIFF_W'(viewer_x) - DIFF_W'(obj_x);
		dy_s1  <= DIFF_W'(viewer_y) - DIFF_W'(obj_y);
		dz_s1  <= DIFF_W'(viewer_z) - DIFF_W'(obj_z);
		// square of a 25-bit value fits in 50 bits and is never negative
		sqx_s2 <= dist_t'(dx_s1 * dx_s1);
		sqy_s2 <= dist_t'(dy_s1 * dy_s1);
		sqz_s2 <= dist_t'(dz_s1 * dz_s1);
		sum_s3 <= sqx_s2 + sqy_s2 + sqz_s2;
	end

	assign out_valid = vld_s3;
	assign dist_sq   = sum_s3;

endmodule

// ===== sv/depth_sort_by_distance_unit.sv =====
// Depth sort by distance, top level: viewer registers, distance store, sort and emit.
// Depends on dsd_pkg and dsd_dist.
//
// Each accepted object keeps busy high while the squared distance goes
// through the three-stage pipeline and is written to the distance store. An
// object that carries last_object then starts the emission: for a set of n
// objects, each result comes after one pass of n reads over the single-port
// distance store and the registered read of its last entry.
// Results are strobed by result_valid for one cycle each and cannot be held
// off; busy is low again from the cycle that shows the final result.
module depth_sort_by_distance_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cfg_we,
	input  logic [dsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsd_pkg::COORD_W-1:0]    cfg_data,
	input  dsd_pkg::coord_t                obj_x,
	input  dsd_pkg::coord_t                obj_y,
	input  dsd_pkg::coord_t                obj_z,
	input  logic                           last_object,
	output logic                           result_valid,
	output logic [dsd_pkg::INDEX_W-1:0]    object_index,
	output dsd_pkg::dist_t                 distance_sq,
	output logic                           last_result,
	output logic                           items_dropped
);
	import dsd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_WAIT
	} state_t;

	state_t state_q;
	coord_t viewer_x_q, viewer_y_q, viewer_z_q;
	cnt_t   count_q;
	logic   overflow_q;
	logic   last_q;
	addr_t  addr_q;
	addr_t  emit_q;
	logic   have_prev_q;
	dist_t  prev_d_q;
	addr_t  prev_a_q;
	logic   best_v_q;
	dist_t  best_d_q;
	addr_t  best_a_q;

	logic   accept;
	logic   dist_valid;
	dist_t  dist_new;

	dist_t  mem [MAX_OBJECTS];
	dist_t  rd_data_s1;
	logic   vld_s1, last_s1;
	addr_t  addr_s1;

	logic   addr_end;
	logic   emit_end;
	logic   cand;
	logic   take;
	dist_t  best_d_n;
	addr_t  best_a_n;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	dsd_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.viewer_x (viewer_x_q),
		.viewer_y (viewer_y_q),
		.viewer_z (viewer_z_q),
		.obj_x    (obj_x),
		.obj_y    (obj_y),
		.obj_z    (obj_z),
		.out_valid(dist_valid),
		.dist_sq  (dist_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_x_q <= '0;
			viewer_y_q <= '0;
			viewer_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VIEWER_X: viewer_x_q <= cfg_data;
				CFG_VIEWER_Y: viewer_y_q <= cfg_data;
				CFG_VIEWER_Z: viewer_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// distance store; load and scan never overlap
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && dist_valid && (count_q < cnt_t'(MAX_OBJECTS)))
			mem[addr_t'(count_q)] <= dist_new;
		if (state_q == ST_SCAN)
			rd_data_s1 <= mem[addr_q];
	end

	assign addr_end = ({1'b0, addr_q} == CNT_W'(count_q - 1'b1));
	assign emit_end = ({1'b0, emit_q} == CNT_W'(count_q - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			addr_s1 <= '0;
		end else begin
			vld_s1  <= (state_q == ST_SCAN);
			last_s1 <= addr_end;
			addr_s1 <= addr_q;
		end
	end

	// next entry in (distance desc, index asc) order after the last one emitted
	always_comb begin
		cand = !have_prev_q || (rd_data_s1 < prev_d_q) ||
		       ((rd_data_s1 == prev_d_q) && (addr_s1 > prev_a_q));
		take = vld_s1 && cand && (!best_v_q || (rd_data_s1 > best_d_q));
		best_d_n = take ? rd_data_s1 : best_d_q;
		best_a_n = take ? addr_s1 : best_a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			overflow_q    <= 1'b0;
			last_q        <= 1'b0;
			addr_q        <= '0;
			emit_q        <= '0;
			have_prev_q   <= 1'b0;
			prev_d_q      <= '0;
			prev_a_q      <= '0;
			best_v_q      <= 1'b0;
			best_d_q      <= '0;
			best_a_q      <= '0;
			result_valid  <= 1'b0;
			object_index  <= '0;
			distance_sq   <= '0;
			last_result   <= 1'b0;
			items_dropped <= 1'b0;
		end else begin
			result_valid <= (state_q == ST_WAIT) && vld_s1 && last_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q  <= last_object;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (dist_valid) begin
						if (count_q < cnt_t'(MAX_OBJECTS))
							count_q <= count_q + 1'b1;
						else
							overflow_q <= 1'b1;
						addr_q      <= '0;
						emit_q      <= '0;
						have_prev_q <= 1'b0;
						best_v_q    <= 1'b0;
						state_q     <= last_q ? ST_SCAN : ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (take) begin
						best_v_q <= 1'b1;
						best_d_q <= best_d_n;
						best_a_q <= best_a_n;
					end
					if (addr_end)
						state_q <= ST_WAIT;
					else
						addr_q <= addr_q + 1'b1;
				end
				ST_WAIT: begin
					if (vld_s1 && last_s1) begin
						object_index  <= INDEX_W'(best_a_n);
						distance_sq   <= best_d_n;
						last_result   <= emit_end;
						items_dropped <= overflow_q;
						have_prev_q   <= 1'b1;
						prev_d_q      <= best_d_n;
						prev_a_q      <= best_a_n;
						best_v_q      <= 1'b0;
						addr_q        <= '0;
						if (emit_end) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							emit_q  <= emit_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end else if (take) begin
						best_v_q <= 1'b1;
						best_d_q <= best_d_n;
						best_a_q <= best_a_n;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |-> busy)
		else $error("result before end of set without busy");
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> (count_q == '0) && !overflow_q)
		else $error("set not cleared after final result");
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (count_q != '0))
		else $error("scan of an empty set");
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results in adjacent cycles");
`endif

endmodule

// ===== sim/tb_depth_sort_by_distance_unit.sv =====
`timescale 1ns / 100ps

// Testbench for depth_sort_by_distance_unit: loads object sets, predicts the
// farthest-first emission order and compares every strobed result field by field.
// Depends on dsd_pkg and the RTL of the unit.
module tb_depth_sort_by_distance_unit;
	import dsd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam coord_t C_MAX = coord_t'(24'h7FFFFF);
	localparam coord_t C_MIN = coord_t'(24'h800000);
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 32;
	localparam int PHASE_ITEMS = 95;
	localparam int IDLE_PCT [4] = '{0, 79, 0, 6};
	localparam int BIG_SET [4] = '{64, 67, 0, 65};

	typedef struct {
		logic [INDEX_W-1:0] index;
		dist_t              dist_sq;
		logic               last;
		logic               dropped;
	} depth_entry_t;

	class depth_order_board;
		coord_t             vx, vy, vz;
		dist_t              dist_mem [MAX_OBJECTS];
		logic [INDEX_W-1:0] index_mem [MAX_OBJECTS];
		int                 count;
		bit                 overflow;
		depth_entry_t       far_to_near [$];
		int                 errors;

		function new();
			vx = '0;
			vy = '0;
			vz = '0;
			count = 0;
			overflow = 1'b0;
			errors = 0;
		endfunction

		function void write_viewer(logic [CFG_IDX_W-1:0] idx, coord_t data);
			unique case (idx)
				CFG_VIEWER_X: vx = data;
				CFG_VIEWER_Y: vy = data;
				CFG_VIEWER_Z: vz = data;
				default: ;
			endcase
		endfunction

		function dist_t sq_diff(coord_t a, coord_t b);
			longint d;
			d = longint'(a) - longint'(b);
			return dist_t'(d * d);
		endfunction

		function void load_object(coord_t x, coord_t y, coord_t z, logic last);
			dist_t              key_d;
			logic [INDEX_W-1:0] key_i;
			depth_entry_t       e;
			int                 i, j;
			if (count < MAX_OBJECTS) begin
				dist_mem[count] = sq_diff(vx, x) + sq_diff(vy, y) + sq_diff(vz, z);
				index_mem[count] = INDEX_W'(count);
				count++;
			end else
				overflow = 1'b1;
			if (!last)
				return;
			// stable, farthest first
			for (i = 1; i < count; i++) begin
				key_d = dist_mem[i];
				key_i = index_mem[i];
				j = i;
				while (j > 0 && dist_mem[j-1] < key_d) begin
					dist_mem[j] = dist_mem[j-1];
					index_mem[j] = index_mem[j-1];
					j--;
				end
				dist_mem[j] = key_d;
				index_mem[j] = key_i;
			end
			for (i = 0; i < count; i++) begin
				e.index = index_mem[i];
				e.dist_sq = dist_mem[i];
				e.last = (i == count - 1);
				e.dropped = overflow;
				far_to_near.push_back(e);
			end
			count = 0;
			overflow = 1'b0;
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		task check_emitted(logic [INDEX_W-1:0] index, dist_t dist_val, logic last,
			logic dropped);
			depth_entry_t e;
			if (far_to_near.size() == 0) begin
				report($sformatf("result with none pending, object_index %0d", index));
				return;
			end
			e = far_to_near.pop_front();
			if (index !== e.index)
				report($sformatf("object_index %0d, want %0d", index, e.index));
			if (dist_val !== e.dist_sq)
				report($sformatf("distance_sq %0d, want %0d (index %0d)", dist_val,
					e.dist_sq, e.index));
			if (last !== e.last)
				report($sformatf("last_result %b, want %b (index %0d)", last, e.last, e.index));
			if (dropped !== e.dropped)
				report($sformatf("items_dropped %b, want %b (index %0d)", dropped, e.dropped,
					e.index));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;
	coord_t               obj_x, obj_y, obj_z;
	logic                 last_object;
	logic                 result_valid;
	logic [INDEX_W-1:0]   object_index;
	dist_t                distance_sq;
	logic                 last_result;
	logic                 items_dropped;

	depth_order_board board = new();

	depth_sort_by_distance_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.obj_x        (obj_x),
		.obj_y        (obj_y),
		.obj_z        (obj_z),
		.last_object  (last_object),
		.result_valid (result_valid),
		.object_index (object_index),
		.distance_sq  (distance_sq),
		.last_result  (last_result),
		.items_dropped(items_dropped)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			board.check_emitted(object_index, distance_sq, last_result, items_dropped);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_viewer(idx, data);
	endtask

	// drain all pending results, then program the viewer; also hits the spare index
	task automatic set_viewer(coord_t x, coord_t y, coord_t z);
		start <= 1'b0;
		while (board.far_to_near.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_VIEWER_X, x);
		write_reg(CFG_SPARE, coord_t'($urandom));
		write_reg(CFG_VIEWER_Y, y);
		write_reg(CFG_VIEWER_Z, z);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// start stays high across back-to-back transfers
	task automatic send_object(coord_t x, coord_t y, coord_t z, logic last, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		obj_x <= x;
		obj_y <= y;
		obj_z <= z;
		last_object <= last;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		board.load_object(x, y, z, last);
	endtask

	function automatic coord_t rand_coord(int kind);
		case (kind)
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(2)) - 1);
			default: return $urandom_range(1) ? C_MAX : C_MIN;
		endcase
	endfunction

	task automatic send_set(int size, int idle_pct);
		int i, k, kind;
		for (i = 0; i < size; i++) begin
			k = $urandom_range(9);
			kind = (k < 6) ? 0 : (k < 9) ? 1 : 2;
			send_object(rand_coord(kind), rand_coord(kind), rand_coord(kind),
				i == size - 1, idle_pct);
		end
	endtask

	initial begin
		int phase, sent, size;
		arst_n <= 1'b0;
		start <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		obj_x <= '0;
		obj_y <= '0;
		obj_z <= '0;
		last_object <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// viewer at origin: single-object set, then equal distances and extremes
		send_object('0, '0, '0, 1'b1, 0);
		send_object(coord_t'(256), '0, '0, 1'b0, 0);
		send_object('0, coord_t'(256), '0, 1'b0, 0);
		send_object('0, '0, coord_t'(-256), 1'b0, 0);
		send_object('0, '0, '0, 1'b0, 0);
		send_object(C_MAX, C_MAX, C_MAX, 1'b0, 0);
		send_object(C_MIN, C_MIN, C_MIN, 1'b1, 0);

		// largest distance, plus zero-distance ties
		set_viewer(C_MIN, C_MIN, C_MIN);
		send_object(C_MAX, C_MAX, C_MAX, 1'b0, 0);
		send_object(C_MIN, C_MIN, C_MIN, 1'b0, 0);
		send_object(C_MAX, C_MIN, '0, 1'b0, 0);
		send_object(C_MIN, C_MIN, C_MIN, 1'b1, 0);

		set_viewer(C_MAX, C_MIN, coord_t'(1));
		send_object(C_MIN, C_MAX, '0, 1'b0, 0);
		send_object(C_MAX, C_MIN, coord_t'(1), 1'b0, 0);
		send_object(C_MIN, C_MAX, coord_t'(2), 1'b1, 0);

		// random sets; large ones fill the store, and the larger ones overflow it
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				1: set_viewer(C_MAX, C_MAX, C_MAX);
				2: set_viewer('0, C_MAX, C_MIN);
				default: set_viewer(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
			endcase
			sent = 0;
			if (BIG_SET[phase] > 0) begin
				send_set(BIG_SET[phase], IDLE_PCT[phase]);
				sent = BIG_SET[phase];
			end
			while (sent < PHASE_ITEMS) begin
				size = $urandom_range(1, 8);
				send_set(size, IDLE_PCT[phase]);
				sent += size;
			end
		end

		start <= 1'b0;
		while (board.far_to_near.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
